// ===== hw/rtl/msdf_pkg.sv =====
// Shared types and constants for the mask slab distance field block.
`timescale 1ns / 1ps
`default_nettype none
package msdf_pkg;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_DEPTH  = 2'd1;
   localparam logic [1:0] CSR_SLAB_HEIGHT = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int GRID_W      = 9;

   localparam logic [GRID_W-1:0]     GRID_WIDTH_RST  = 9'd0;
   localparam logic [GRID_W-1:0]     GRID_DEPTH_RST  = 9'd0;
   localparam logic [CSR_DATA_W-1:0] SLAB_HEIGHT_RST = 31'd524288;

   // controller -> datapath
   typedef struct packed {
      logic       clear;     // clearing pass, one node per cycle
      logic       node_wr;   // write word accepted this cycle
      logic       load;      // query word accepted this cycle
      logic       rd_en;     // read one corner node
      logic [1:0] corner;    // bit 0: x + 1, bit 1: z + 1
      logic       fill;      // accumulator final, form fill term
      logic       out_load;  // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/msdf_datapath.sv =====
// Datapath: node memory, csr registers, bilinear accumulate, slab term and result.
`timescale 1ns / 1ps
`default_nettype none
module msdf_datapath #(
   parameter int MAX_GRID_X = 256,
   parameter int MAX_GRID_Z = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  msdf_pkg::cmd_type                   cmd,
   output msdf_pkg::status_type                status,
   input  wire  [7:0]                          req_node_x,
   input  wire  [7:0]                          req_node_z,
   input  wire                                 req_node_on,
   input  wire  signed [31:0]                  req_point_x,
   input  wire  signed [31:0]                  req_point_y,
   input  wire  signed [31:0]                  req_point_z,
   input  wire                                 csr_wr_en,
   input  wire  [msdf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [msdf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic signed [31:0]                  rsp_distance
);

   localparam int XW    = $clog2(MAX_GRID_X);
   localparam int ZW    = $clog2(MAX_GRID_Z);
   localparam int AW    = XW + ZW;
   localparam int DEPTH = 1 << AW;

   // csr registers
   logic [msdf_pkg::GRID_W-1:0]     grid_width_ff;
   logic [msdf_pkg::GRID_W-1:0]     grid_depth_ff;
   logic [msdf_pkg::CSR_DATA_W-1:0] slab_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= msdf_pkg::GRID_WIDTH_RST;
         grid_depth_ff  <= msdf_pkg::GRID_DEPTH_RST;
         slab_height_ff <= msdf_pkg::SLAB_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            msdf_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[msdf_pkg::GRID_W-1:0];
            msdf_pkg::CSR_GRID_DEPTH:  grid_depth_ff  <= csr_wdata[msdf_pkg::GRID_W-1:0];
            msdf_pkg::CSR_SLAB_HEIGHT: slab_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective grid size, capped at storage size
   logic [msdf_pkg::GRID_W-1:0] gw_eff;
   logic [msdf_pkg::GRID_W-1:0] gd_eff;
   logic                        grid_ok;

   always_comb begin
      gw_eff  = (32'(grid_width_ff) > MAX_GRID_X) ? msdf_pkg::GRID_W'(MAX_GRID_X)
                                                   : grid_width_ff;
      gd_eff  = (32'(grid_depth_ff) > MAX_GRID_Z) ? msdf_pkg::GRID_W'(MAX_GRID_Z)
                                                   : grid_depth_ff;
      grid_ok = (gw_eff > 9'd1) && (gd_eff > 9'd1);
   end

   // clearing pass counter
   logic [AW-1:0] clear_addr_ff;
   logic [AW-1:0] clear_addr_in;

   assign clear_addr_in     = cmd.clear ? clear_addr_ff + 1'b1 : clear_addr_ff;
   assign status.clear_last = (clear_addr_ff == {AW{1'b1}});

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else begin
         clear_addr_ff <= clear_addr_in;
      end
   end

   // query word registers
   logic [15:0]        ix_ff;
   logic [15:0]        iz_ff;
   logic [15:0]        fx_ff;
   logic [15:0]        fz_ff;
   logic signed [33:0] a_ff;
   logic signed [33:0] q2_ff;
   logic signed [33:0] a_in;
   logic signed [33:0] q2_in;
   logic        [33:0] a_abs;

   // slab term at doubled scale: a = 2y - h, q2 = |a| - h
   always_comb begin
      a_in  = {req_point_y[31], req_point_y, 1'b0} - {3'b000, slab_height_ff};
      a_abs = a_ff[33] ? -a_ff : a_ff;
      q2_in = a_abs - {3'b000, slab_height_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ix_ff <= req_point_x[31:16];
         iz_ff <= req_point_z[31:16];
         fx_ff <= req_point_x[15:0];
         fz_ff <= req_point_z[15:0];
         a_ff  <= a_in;
      end
      q2_ff <= q2_in;
   end

   // corner node select
   logic [16:0]   cx;
   logic [16:0]   cz;
   logic          x_ok;
   logic          z_ok;
   logic          hit;
   logic [AW-1:0] rd_addr;
   logic [16:0]   gx;
   logic [16:0]   gz;
   logic [16:0]   wa;
   logic [16:0]   wb;

   always_comb begin
      cx      = {ix_ff[15], ix_ff} + {16'd0, cmd.corner[0]};
      cz      = {iz_ff[15], iz_ff} + {16'd0, cmd.corner[1]};
      x_ok    = !cx[16] && (cx[15:0] < {7'd0, gw_eff});
      z_ok    = !cz[16] && (cz[15:0] < {7'd0, gd_eff});
      hit     = x_ok && z_ok && grid_ok;
      rd_addr = {ZW'(cz), XW'(cx)};
      gx      = 17'h10000 - {1'b0, fx_ff};
      gz      = 17'h10000 - {1'b0, fz_ff};
      wa      = cmd.corner[0] ? {1'b0, fx_ff} : gx;
      wb      = cmd.corner[1] ? {1'b0, fz_ff} : gz;
   end

   // node memory, one bit per node, address {z, x}
   logic          node_mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wbit;
   logic          wr_in_store;
   logic          rd_bit_ff;

   always_comb begin
      wr_in_store = (32'(req_node_x) < MAX_GRID_X) && (32'(req_node_z) < MAX_GRID_Z);
      mem_we      = cmd.clear || (cmd.node_wr && wr_in_store);
      mem_waddr   = cmd.clear ? clear_addr_ff : {ZW'(req_node_z), XW'(req_node_x)};
      mem_wbit    = cmd.clear ? 1'b0 : req_node_on;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wbit;
      end
      if (cmd.rd_en) begin
         rd_bit_ff <= node_mem[rd_addr];
      end
   end

   // weight pipeline: read -> multiply -> accumulate
   logic        hit_ff;
   logic [16:0] wa_ff;
   logic [16:0] wb_ff;
   logic        v1_ff;
   logic        v2_ff;
   logic [33:0] prod_full;
   logic [32:0] prod_in;
   logic [32:0] prod_ff;
   logic [32:0] acc_ff;

   always_comb begin
      prod_full = wa_ff * wb_ff;
      prod_in   = (rd_bit_ff && hit_ff) ? prod_full[32:0] : 33'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         hit_ff <= hit;
         wa_ff  <= wa;
         wb_ff  <= wb;
      end
      prod_ff <= prod_in;
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
      end
   end

   // fill rounded to Q1.16, then 2 * (0.5 - fill)
   logic [33:0]        acc_round;
   logic [16:0]        fill;
   logic signed [17:0] d2_ff;

   always_comb begin
      acc_round = {1'b0, acc_ff} + 34'd32768;
      fill      = acc_round[32:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         d2_ff <= 18'h10000 - {fill, 1'b0};
      end
   end

   // max of the two terms, halve toward minus infinity, saturate
   logic signed [33:0] d2x;
   logic signed [33:0] m;
   logic        [32:0] r;
   logic        [31:0] dist_in;
   logic signed [31:0] rsp_distance_ff;

   always_comb begin
      d2x = {{16{d2_ff[17]}}, d2_ff};
      m   = (d2x > q2_ff) ? d2x : q2_ff;
      r   = m[33:1];
      if (r[32] != r[31]) begin
         dist_in = r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         dist_in = r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_distance_ff <= dist_in;
      end
   end

   assign rsp_distance = rsp_distance_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/msdf_ctrl.sv =====
// Controller: clearing pass, corner read sequence and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module msdf_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_opcode,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output msdf_pkg::cmd_type     cmd,
   input  msdf_pkg::status_type  status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_FILL,
      S_DONE
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      accept    = req_valid && req_ready;

      cmd          = '0;
      cmd.clear    = (state_ff == S_CLEAR);
      cmd.node_wr  = accept && (req_opcode == msdf_pkg::OP_WRITE);
      cmd.load     = accept && (req_opcode == msdf_pkg::OP_QUERY);
      cmd.rd_en    = (state_ff == S_READ);
      cmd.corner   = cnt_ff;
      cmd.fill     = (state_ff == S_FILL);
      cmd.out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_READ;
               cnt_in   = 2'd0;
            end
         end
         S_READ: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = S_DRAIN;
               cnt_in   = 2'd0;
            end
         end
         S_DRAIN: begin
            // wait for the last product to pass the product register into the accumulator
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd.out_load) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // result register is never overwritten while a word is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending word");

   // a query reaches the fill step after four reads and the drain state
   a_query_timing: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == msdf_pkg::OP_QUERY) |-> ##7 (state_ff == S_FILL))
      else $error("query sequence timing broken");

   // node writes never collide with the clearing pass
   a_write_vs_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.node_wr && cmd.clear))
      else $error("node write during clearing pass");

   // a new result follows only a query read sequence
   a_done_from_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> ($past(state_ff) == S_FILL || $past(state_ff) == S_DONE))
      else $error("done state entered out of sequence");

endmodule
`default_nettype wire

// ===== hw/rtl/mask_slab_distance_field.sv =====
// Top level of the mask slab distance field: controller plus datapath.
// Write word: accepted in the idle state, ready again the next cycle.
// Query word: four corner reads on one memory port, a two-stage multiply/accumulate drain,
//   a fill state and a result state; the result waits in S_DONE while the result slot is
//   busy, and no new word is taken until the query is through.
// Reset: a clearing pass zeroes the node memory one node per cycle,
//   all 2**(clog2(MAX_GRID_X) + clog2(MAX_GRID_Z)) nodes (65536 at defaults), req_ready low.
`timescale 1ns / 1ps
`default_nettype none
module mask_slab_distance_field #(
   parameter int MAX_GRID_X = 256,
   parameter int MAX_GRID_Z = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_opcode,
   input  wire  [7:0]                          req_node_x,
   input  wire  [7:0]                          req_node_z,
   input  wire                                 req_node_on,
   input  wire  signed [31:0]                  req_point_x,
   input  wire  signed [31:0]                  req_point_y,
   input  wire  signed [31:0]                  req_point_z,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [31:0]                  rsp_distance,
   input  wire                                 csr_wr_en,
   input  wire  [msdf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [msdf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   msdf_pkg::cmd_type    cmd;
   msdf_pkg::status_type status;

   msdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   msdf_datapath #(
      .MAX_GRID_X (MAX_GRID_X),
      .MAX_GRID_Z (MAX_GRID_Z)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_node_x   (req_node_x),
      .req_node_z   (req_node_z),
      .req_node_on  (req_node_on),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_distance (rsp_distance)
   );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the mask slab distance field: directed and random words, checked bit-exact.
`timescale 1ns / 1ps
module tb;

   localparam int MAP_SIDE = 256;            // node storage per axis at default parameters
   localparam int WINDOW = 8;                // nodes per axis in the write window of one random phase
   localparam int PHASES = 8;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int QUIET_CYCLES = 20;
   localparam int LONG_HOLD = 400;
   // the clearing pass runs without a handshake
   localparam int WATCHDOG_LIMIT = 250000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int unsigned PHASE_W [PHASES] = '{16, 256, 511, 1, 2, 0, 37, 256};
   localparam int unsigned PHASE_D [PHASES] = '{16, 256, 300, 200, 2, 0, 256, 1};
   localparam int unsigned PHASE_H [PHASES] =
      '{32'h0008_0000, 32'h0003_4000, 0, 32'h0014_8000, 32'h7FFF_FFFF,
        32'h0001_0000, 32'h0000_5555, 32'h0040_0000};

   typedef struct {
      logic              opcode;
      logic [7:0]        node_x;
      logic [7:0]        node_z;
      logic              node_on;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } mask_word_type;

   // Mirror of the node map and registers; holds the distances still owed by the block.
   class slab_field_board_type;
      bit                 filled [MAP_SIDE][MAP_SIDE];  // [z][x]
      bit [8:0]           grid_width;
      bit [8:0]           grid_depth;
      bit [30:0]          slab_height;
      logic signed [31:0] pending_distances [$];
      int                 failures;

      function new();
         grid_width  = msdf_pkg::GRID_WIDTH_RST;
         grid_depth  = msdf_pkg::GRID_DEPTH_RST;
         slab_height = msdf_pkg::SLAB_HEIGHT_RST;
         failures    = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [30:0] data);
         case (index)
            msdf_pkg::CSR_GRID_WIDTH:  grid_width  = data[8:0];
            msdf_pkg::CSR_GRID_DEPTH:  grid_depth  = data[8:0];
            msdf_pkg::CSR_SLAB_HEIGHT: slab_height = data;
            default: ;
         endcase
      endfunction

      function bit node_lit(longint x, longint z);
         longint gw, gd;
         gw = (grid_width > MAP_SIDE) ? MAP_SIDE : longint'(grid_width);
         gd = (grid_depth > MAP_SIDE) ? MAP_SIDE : longint'(grid_depth);
         if (gw <= 1 || gd <= 1)
            return 1'b0;
         if (x < 0 || x >= gw || z < 0 || z >= gd)
            return 1'b0;
         return filled[z][x];
      endfunction

      function logic signed [31:0] predict_distance(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
         longint ix, iz, fx, fz, gx, gz, sum, fill, d2, a, q2, m, r;
         ix = longint'(px) >>> 16;
         iz = longint'(pz) >>> 16;
         fx = longint'(px) - ix * 65536;
         fz = longint'(pz) - iz * 65536;
         gx = 65536 - fx;
         gz = 65536 - fz;
         sum = 0;
         if (node_lit(ix, iz))         sum += gx * gz;
         if (node_lit(ix + 1, iz))     sum += fx * gz;
         if (node_lit(ix, iz + 1))     sum += gx * fz;
         if (node_lit(ix + 1, iz + 1)) sum += fx * fz;
         fill = (sum + 32768) >>> 16;
         // doubled scale keeps h/2 exact
         d2 = 2 * (32768 - fill);
         a = 2 * longint'(py) - longint'(slab_height);
         if (a < 0)
            a = -a;
         q2 = a - longint'(slab_height);
         m = (d2 > q2) ? d2 : q2;
         r = m >>> 1;
         if (r > 64'sd2147483647)
            r = 64'sd2147483647;
         if (r < -64'sd2147483648)
            r = -64'sd2147483648;
         return r[31:0];
      endfunction

      function void note_word(mask_word_type w);
         if (w.opcode == msdf_pkg::OP_WRITE)
            filled[w.node_z][w.node_x] = w.node_on;
         else
            pending_distances.push_back(predict_distance(w.point_x, w.point_y, w.point_z));
      endfunction

      function void check_distance(logic signed [31:0] got);
         logic signed [31:0] want;
         if (pending_distances.size() == 0) begin
            failures++;
            $display("%0t: distance %0d arrived with nothing pending", $time, got);
            return;
         end
         want = pending_distances.pop_front();
         if (got !== want) begin
            failures++;
            $display("%0t: distance mismatch, expected %0d actual %0d", $time, want, got);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_opcode = msdf_pkg::OP_WRITE;
   logic [7:0]        req_node_x = '0;
   logic [7:0]        req_node_z = '0;
   logic              req_node_on = 1'b0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [31:0] rsp_distance;
   logic              csr_wr_en = 1'b0;
   logic [msdf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [msdf_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned sender_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_count = 0;

   slab_field_board_type board = new();

   mask_slab_distance_field DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_node_x   (req_node_x),
      .req_node_z   (req_node_z),
      .req_node_on  (req_node_on),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_ports
      mask_word_type seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.opcode  = req_opcode;
            seen.node_x  = req_node_x;
            seen.node_z  = req_node_z;
            seen.node_on = req_node_on;
            seen.point_x = req_point_x;
            seen.point_y = req_point_y;
            seen.point_z = req_point_z;
            board.note_word(seen);
         end
         if (rsp_valid && rsp_ready)
            board.check_distance(rsp_distance);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_count = 0;
      else
         quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic mask_word_type make_write(logic [7:0] x, logic [7:0] z, logic on);
      mask_word_type w;
      w.opcode  = msdf_pkg::OP_WRITE;
      w.node_x  = x;
      w.node_z  = z;
      w.node_on = on;
      w.point_x = $urandom;
      w.point_y = $urandom;
      w.point_z = $urandom;
      return w;
   endfunction

   function automatic mask_word_type make_query(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz);
      mask_word_type w;
      w.opcode  = msdf_pkg::OP_QUERY;
      w.node_x  = 8'($urandom);
      w.node_z  = 8'($urandom);
      w.node_on = 1'($urandom);
      w.point_x = px;
      w.point_y = py;
      w.point_z = pz;
      return w;
   endfunction

   // window sits at the low edge, the high edge, or anywhere inside the grid in use
   function automatic int unsigned window_base(int unsigned eff);
      if (eff <= WINDOW)
         return 0;
      case ($urandom_range(2))
         0: return 0;
         1: return eff - WINDOW;
         default: return $urandom_range(eff - WINDOW);
      endcase
   endfunction

   // one node below the window up to one past it, sometimes on a node exactly, sometimes anywhere
   function automatic logic [31:0] window_point(int unsigned base);
      longint c;
      int unsigned sel;
      sel = $urandom_range(7);
      if (sel == 0)
         return $urandom;
      c = (longint'(base) + longint'($urandom_range(WINDOW + 1)) - 1) * 65536;
      if (sel != 1)
         c += longint'($urandom_range(65535));
      return c[31:0];
   endfunction

   // near the slab bottom, middle or top, or anywhere
   function automatic logic [31:0] slab_point(int unsigned h);
      longint anchor;
      case ($urandom_range(3))
         0: return $urandom;
         1: anchor = 0;
         2: anchor = longint'(h) / 2;
         default: anchor = longint'(h);
      endcase
      anchor += longint'($urandom_range(8 << 16)) - (4 << 16);
      return anchor[31:0];
   endfunction

   function automatic mask_word_type random_word(int unsigned bx, int unsigned bz,
                                                 int unsigned h);
      logic [7:0] x, z;
      if ($urandom_range(99) < 35) begin
         x = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(bx + $urandom_range(WINDOW - 1));
         z = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(bz + $urandom_range(WINDOW - 1));
         return make_write(x, z, $urandom_range(99) < 70);
      end
      return make_query(window_point(bx), slab_point(h), window_point(bz));
   endfunction

   task automatic offer_word(mask_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= w.opcode;
      req_node_x  <= w.node_x;
      req_node_z  <= w.node_z;
      req_node_on <= w.node_on;
      req_point_x <= w.point_x;
      req_point_y <= w.point_y;
      req_point_z <= w.point_z;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // writes never answer, so give the block its full latency after the last distance
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (board.pending_distances.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(int unsigned gw, int unsigned gd, int unsigned h);
      logic [1:0]  regs [4];
      logic [30:0] vals [4];
      regs[0] = msdf_pkg::CSR_GRID_WIDTH;  vals[0] = 31'(gw);
      regs[1] = msdf_pkg::CSR_GRID_DEPTH;  vals[1] = 31'(gd);
      regs[2] = msdf_pkg::CSR_SLAB_HEIGHT; vals[2] = 31'(h);
      regs[3] = CSR_UNUSED;                vals[3] = 31'($urandom);
      for (int k = 0; k < 4; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[k];
         csr_wdata <= vals[k];
         @(posedge clock);
         board.set_register(regs[k], vals[k]);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned eff_w, eff_d, base_x, base_z;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // clearing pass
      do @(posedge clock); while (req_ready !== 1'b1);

      // reset register values: empty grid, slab 0..8
      offer_word(make_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      settle_idle();
      apply_setting(4, 4, 32'h0008_0000);

      offer_word(make_write(8'd0, 8'd0, 1'b1));
      offer_word(make_write(8'd1, 8'd0, 1'b1));
      offer_word(make_write(8'd0, 8'd1, 1'b1));
      offer_word(make_write(8'd1, 8'd1, 1'b1));
      offer_word(make_write(8'd3, 8'd3, 1'b1));
      offer_word(make_write(8'd255, 8'd255, 1'b1));  // stored but outside the grid in use
      offer_word(make_write(8'd2, 8'd2, 1'b1));
      offer_word(make_write(8'd2, 8'd2, 1'b0));      // cleared again
      offer_word(make_query(32'h0000_0000, 32'h0004_0000, 32'h0000_0000));
      offer_word(make_query(32'h0000_8000, 32'h0004_0000, 32'h0000_8000));
      offer_word(make_query(32'h0001_8000, 32'h0004_0000, 32'h0001_8000));
      offer_word(make_query(32'hFFFF_8000, 32'h0004_0000, 32'h0000_0000));
      offer_word(make_query(32'h0003_4000, 32'h0004_0000, 32'h0003_C000));
      offer_word(make_query(32'h00FF_0000, 32'h0004_0000, 32'h00FF_0000));
      offer_word(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      offer_word(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      offer_word(make_query(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000));
      offer_word(make_query(32'h0000_0000, 32'h0008_0000, 32'h0000_0000));

      for (int phase = 0; phase < PHASES; phase++) begin
         settle_idle();
         apply_setting(PHASE_W[phase], PHASE_D[phase], PHASE_H[phase]);
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
            end
            1: begin
               sender_idle_pct = 72;
               recv_stall_pct  = 0;
            end
            2: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 72;
            end
            default: begin
               sender_idle_pct = 13;
               recv_stall_pct  = 13;
            end
         endcase
         eff_w  = (PHASE_W[phase] > MAP_SIDE) ? MAP_SIDE : PHASE_W[phase];
         eff_d  = (PHASE_D[phase] > MAP_SIDE) ? MAP_SIDE : PHASE_D[phase];
         base_x = window_base(eff_w);
         base_z = window_base(eff_d);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // back up the result path while words keep coming
            if (phase % 4 == 0 && n == 20)
               hold_requests++;
            offer_word(random_word(base_x, base_z, PHASE_H[phase]));
         end
      end

      settle_idle();
      if (board.failures == 0 && board.pending_distances.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/msdf_pkg.sv
hw/rtl/msdf_datapath.sv
hw/rtl/msdf_ctrl.sv
hw/rtl/mask_slab_distance_field.sv
test/tb.sv
